>>> rtl/ssq_pkg.sv
// Shared types and constants of the sorted sleep and wakeup queue.
package ssq_pkg;

  localparam int unsigned ThreadIdWidth  = 8;
  localparam int unsigned TickWidth      = 63;
  localparam int unsigned InDataWidth    = 72;
  localparam int unsigned OutDataWidth   = 8;
  localparam int unsigned CmdFifoDepth   = 2;

  typedef enum logic {
    KIND_SLEEP = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_WAKE
  } state_e;

  typedef struct packed {
    kind_e                    kind;
    logic [ThreadIdWidth-1:0] thread_id;
    logic [TickWidth-1:0]     time_value;
  } cmd_t;

endpackage

>>> rtl/ssq_front.sv
// Input side: accepts words, decodes the action and buffers commands in a short queue.
module ssq_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [ssq_pkg::InDataWidth-1:0] s_axis_tdata_i,
  input  logic                         s_axis_tuser_i,
  output logic                         cmd_valid_o,
  input  logic                         cmd_ready_i,
  output ssq_pkg::cmd_t                cmd_o
);
  import ssq_pkg::*;

  localparam int unsigned PtrWidth = $clog2(CmdFifoDepth);
  localparam int unsigned CntWidth = $clog2(CmdFifoDepth + 1);

  cmd_t                mem_q [CmdFifoDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                push, pop;
  cmd_t                cmd_in;

  always_comb begin
    unique case (s_axis_tuser_i)
      1'b0:    cmd_in.kind = KIND_SLEEP;
      default: cmd_in.kind = KIND_TICK;
    endcase
    cmd_in.thread_id  = s_axis_tdata_i[ThreadIdWidth-1:0];
    cmd_in.time_value = s_axis_tdata_i[ThreadIdWidth+TickWidth-1:ThreadIdWidth];
  end

  assign s_axis_tready_o = (cnt_q != CntWidth'(CmdFifoDepth));
  assign cmd_valid_o     = (cnt_q != '0);
  assign cmd_o           = mem_q[rd_ptr_q];
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(CmdFifoDepth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(CmdFifoDepth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntWidth'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

>>> rtl/ssq_back.sv
// Execution side: the sorted sleeper store, its control and the result register.
module ssq_back #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  ssq_pkg::cmd_t                     cmd_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [ssq_pkg::OutDataWidth-1:0]  m_axis_tdata_o,
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);
  import ssq_pkg::*;

  localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);

  logic [TickWidth-1:0]     ticks_q [QUEUE_DEPTH];
  logic [TickWidth-1:0]     ticks_d [QUEUE_DEPTH];
  logic [ThreadIdWidth-1:0] ids_q   [QUEUE_DEPTH];
  logic [ThreadIdWidth-1:0] ids_d   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]   lt;
  logic [CntWidth-1:0]      count_q, count_d;
  logic [TickWidth-1:0]     tick_q;
  state_e                   state_q, state_d;

  logic                     out_valid_q, out_valid_d;
  logic [ThreadIdWidth-1:0] out_id_q;
  logic                     out_ovf_q, out_last_q;

  logic can_load, head_due, last_hit, is_full;
  logic do_insert, do_pop, load_ovf, tick_load;

  assign can_load = !out_valid_q || m_axis_tready_i;
  assign head_due = (count_q != '0) && (ticks_q[0] <= tick_q);
  assign last_hit = (count_q == CntWidth'(1)) || (ticks_q[1] > tick_q);
  assign is_full  = (count_q == CntWidth'(QUEUE_DEPTH));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == KIND_TICK)) begin
          state_d = ST_WAKE;
        end
      end
      ST_WAKE: begin
        if (!head_due) begin
          state_d = ST_IDLE;
        end else if (can_load && last_hit) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready_o = 1'b0;
    do_insert   = 1'b0;
    do_pop      = 1'b0;
    load_ovf    = 1'b0;
    tick_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            KIND_SLEEP: begin
              if (is_full) begin
                cmd_ready_o = can_load;
                load_ovf    = can_load;
              end else begin
                cmd_ready_o = 1'b1;
                do_insert   = 1'b1;
              end
            end
            default: begin
              cmd_ready_o = 1'b1;
              tick_load   = 1'b1;
            end
          endcase
        end
      end
      ST_WAKE: begin
        do_pop = head_due && can_load;
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    assign lt[i] = (CntWidth'(i) < count_q) && (ticks_q[i] < cmd_i.time_value);

    always_comb begin
      ticks_d[i] = ticks_q[i];
      ids_d[i]   = ids_q[i];
      if (do_insert) begin
        if (!lt[i]) begin
          if (i == 0) begin
            ticks_d[i] = cmd_i.time_value;
            ids_d[i]   = cmd_i.thread_id;
          end else if (lt[(i == 0) ? 0 : i-1]) begin
            ticks_d[i] = cmd_i.time_value;
            ids_d[i]   = cmd_i.thread_id;
          end else begin
            ticks_d[i] = ticks_q[(i == 0) ? 0 : i-1];
            ids_d[i]   = ids_q[(i == 0) ? 0 : i-1];
          end
        end
      end else if (do_pop) begin
        if (i < QUEUE_DEPTH - 1) begin
          ticks_d[i] = ticks_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
          ids_d[i]   = ids_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CntWidth'(1);
    end else if (do_pop) begin
      count_d = count_q - CntWidth'(1);
    end
    if (do_pop || load_ovf) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ticks_q[i] <= ticks_d[i];
      ids_q[i]   <= ids_d[i];
    end
    if (tick_load) begin
      tick_q <= cmd_i.time_value;
    end
    if (do_pop) begin
      out_id_q   <= ids_q[0];
      out_ovf_q  <= 1'b0;
      out_last_q <= last_hit;
    end else if (load_ovf) begin
      out_id_q   <= '0;
      out_ovf_q  <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_id_q;
  assign m_axis_tuser_o  = out_ovf_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

>>> rtl/sorted_sleep_wakeup_queue.sv
// Top level of the sorted sleep and wakeup queue.
//
// The slave stream carries one command word per transfer: tuser selects a sleep (0) or a
// timer tick (1), tdata holds the thread id and the 63-bit time. The master stream carries
// one word per woken thread, or one overflow word for a sleep into a full queue.
// A command word is registered in a two-entry command queue, whose head feeds the queue
// engine. A sleep into a queue that is not full is inserted into the sorted store and
// gives no word. A tick latches the time; then each due thread is popped from the head
// and registered for output, one per cycle while the output register can be loaded,
// with tlast on the final one. A tick with nothing due gives no word. While a tick wakes
// threads the engine takes no new command; the head compares decide when it returns to
// idle. A tick's first word passes the state register and then the output register; an
// overflow word is loaded into the output register as its sleep is accepted.
// When the receiver holds tready low, the output register keeps its word and the engine
// waits as soon as it has another word to load, while sleeps that give no word still go
// in. The command queue keeps accepting until both of its entries are taken.
// Reset empties the store and both streams; stored entries are not cleared.
module sorted_sleep_wakeup_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // thread_id [7:0], time_value [70:8], zero [71]
  input  logic        s_axis_tuser_i,  // action [0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // woken_thread [7:0]
  output logic        m_axis_tuser_o,  // overflow [0]
  output logic        m_axis_tlast_o
);
  import ssq_pkg::*;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  ssq_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_ready_i     (cmd_ready),
    .cmd_o           (cmd)
  );

  ssq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

>>> test/sorted_sleep_wakeup_queue_test.sv
// Self-checking testbench of the sorted sleep and wakeup queue with a stream driver and monitor.
module sorted_sleep_wakeup_queue_test;
  import ssq_pkg::*;

  localparam int unsigned QueueDepth = 16;
  localparam logic [TickWidth-1:0] TickMax = {TickWidth{1'b1}};

  typedef struct {
    kind_e                    kind;
    logic [ThreadIdWidth-1:0] thread_id;
    logic [TickWidth-1:0]     time_value;
    bit                       drain_first;
  } request_t;

  typedef struct {
    logic [ThreadIdWidth-1:0] woken_thread;
    logic                     overflow;
    logic                     last;
  } wakeup_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [InDataWidth-1:0]   s_axis_tdata = '0;
  logic                     s_axis_tuser = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0]  m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     m_axis_tlast;

  sorted_sleep_wakeup_queue #(
    .QUEUE_DEPTH(QueueDepth)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

  request_t               pending_requests[$];
  request_t               current_request;
  wakeup_t                expected_wakeups[$];
  logic [TickWidth-1:0]   sleep_ticks[QueueDepth];
  logic [ThreadIdWidth-1:0] sleep_ids[QueueDepth];
  int                     sleeper_count = 0;
  int                     requests_total = 0;
  int                     requests_sent = 0;
  int                     words_seen = 0;
  int                     overflows_seen = 0;
  int                     longest_burst = 0;
  int                     mismatches = 0;
  int                     holdoff_left = 0;
  bit                     holdoff_done = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  task automatic queue_request(input kind_e kind, input logic [ThreadIdWidth-1:0] thread_id,
                               input logic [TickWidth-1:0] time_value, input bit drain_first);
    request_t req;
    req.kind        = kind;
    req.thread_id   = thread_id;
    req.time_value  = time_value;
    req.drain_first = drain_first;
    pending_requests.push_back(req);
    requests_total++;
  endtask

  task automatic predict_wakeups(input request_t req);
    int      pos;
    int      due;
    wakeup_t res;
    if (req.kind == KIND_SLEEP) begin
      if (sleeper_count >= QueueDepth) begin
        res = '{woken_thread: '0, overflow: 1'b1, last: 1'b1};
        expected_wakeups.push_back(res);
      end else begin
        pos = 0;
        while (pos < sleeper_count && sleep_ticks[pos] < req.time_value) pos++;
        for (int i = sleeper_count; i > pos; i--) begin
          sleep_ticks[i] = sleep_ticks[i-1];
          sleep_ids[i]   = sleep_ids[i-1];
        end
        sleep_ticks[pos] = req.time_value;
        sleep_ids[pos]   = req.thread_id;
        sleeper_count++;
      end
    end else begin
      due = 0;
      while (due < sleeper_count && sleep_ticks[due] <= req.time_value) due++;
      for (int i = 0; i < due; i++) begin
        res = '{woken_thread: sleep_ids[i], overflow: 1'b0, last: (i == due - 1)};
        expected_wakeups.push_back(res);
      end
      for (int i = due; i < sleeper_count; i++) begin
        sleep_ticks[i-due] = sleep_ticks[i];
        sleep_ids[i-due]   = sleep_ids[i];
      end
      sleeper_count -= due;
      if (due > longest_burst) longest_burst = due;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_wakeups(current_request);
        requests_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_requests.size() > 0 &&
            !(pending_requests[0].drain_first && expected_wakeups.size() != 0) &&
            !((requests_sent < 350 || requests_sent >= 450) && $urandom_range(0, 99) < 8)) begin
          current_request = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, current_request.time_value, current_request.thread_id};
          s_axis_tuser  <= current_request.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_left <= 0;
      holdoff_done <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && requests_sent >= 100) begin
      holdoff_left <= 400;
      holdoff_done <= 1'b1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    wakeup_t exp_word;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_seen++;
        if (m_axis_tuser) overflows_seen++;
        if (expected_wakeups.size() == 0) begin
          report_mismatch($sformatf("unexpected word thread=%0d overflow=%0b last=%0b",
                                    m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end else begin
          exp_word = expected_wakeups.pop_front();
          if (m_axis_tdata !== exp_word.woken_thread)
            report_mismatch($sformatf("woken_thread %0d, expected %0d",
                                      m_axis_tdata, exp_word.woken_thread));
          if (m_axis_tuser !== exp_word.overflow)
            report_mismatch($sformatf("overflow %0b, expected %0b",
                                      m_axis_tuser, exp_word.overflow));
          if (m_axis_tlast !== exp_word.last)
            report_mismatch($sformatf("last %0b, expected %0b", m_axis_tlast, exp_word.last));
        end
      end
      if (holdoff_left > 0)
        m_axis_tready <= 1'b0;
      else if (requests_sent >= 350 && requests_sent < 450)
        m_axis_tready <= 1'b1;
      else
        m_axis_tready <= ($urandom_range(0, 99) >= 8);
    end
  end

  initial begin
    logic [TickWidth-1:0] now;
    logic [TickWidth-1:0] rnd;
    int                   pick;

    queue_request(KIND_TICK, 8'd0, '0, 1'b0);
    queue_request(KIND_SLEEP, 8'd255, '0, 1'b0);
    queue_request(KIND_SLEEP, 8'd0, TickMax, 1'b0);
    queue_request(KIND_TICK, 8'd7, '0, 1'b0);
    queue_request(KIND_TICK, 8'd0, TickMax, 1'b0);
    queue_request(KIND_SLEEP, 8'd1, 63'd100, 1'b0);
    queue_request(KIND_SLEEP, 8'd2, 63'd100, 1'b0);
    queue_request(KIND_SLEEP, 8'd3, 63'd50, 1'b0);
    queue_request(KIND_TICK, 8'd0, 63'd99, 1'b0);
    queue_request(KIND_TICK, 8'd0, 63'd49, 1'b0);
    queue_request(KIND_TICK, 8'd0, 63'd100, 1'b0);
    for (int i = 0; i < QueueDepth; i++)
      queue_request(KIND_SLEEP, 8'(16 + i), 63'(1000 + 7 * ((i * 5) % QueueDepth)), 1'b0);
    queue_request(KIND_SLEEP, 8'd200, 63'd5, 1'b0);
    queue_request(KIND_TICK, 8'd0, TickMax, 1'b0);

    now = 63'd2000;
    for (int n = 0; n < 500; n++) begin
      pick = $urandom_range(0, 99);
      rnd  = TickWidth'({$urandom, $urandom});
      if (pick < 5)
        queue_request(KIND_SLEEP, 8'($urandom), rnd, n == 250);
      else if (pick < 8)
        queue_request(KIND_TICK, 8'($urandom), rnd, n == 250);
      else if (pick < 60)
        queue_request(KIND_SLEEP, 8'($urandom), now + 63'($urandom_range(0, 60)), n == 250);
      else begin
        now = now + 63'($urandom_range(0, 30));
        queue_request(KIND_TICK, 8'($urandom), now, n == 250);
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (requests_sent == requests_total);
    wait (expected_wakeups.size() == 0);
    repeat (50) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d words, %0d of them overflow reports.",
             requests_sent, words_seen, overflows_seen);
    $display("Largest wakeup burst was %0d threads; %0d threads still asleep at the end.",
             longest_burst, sleeper_count);
    if (mismatches == 0 && expected_wakeups.size() == 0) begin
      $display("sorted_sleep_wakeup_queue regression: pass");
    end else begin
      $display("sorted_sleep_wakeup_queue regression: fail");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("sorted_sleep_wakeup_queue regression: fail");
    $finish;
  end

endmodule

>>> files.f
rtl/ssq_pkg.sv
rtl/ssq_front.sv
rtl/ssq_back.sv
rtl/sorted_sleep_wakeup_queue.sv
test/sorted_sleep_wakeup_queue_test.sv
